// File: hdl/spatial_cell_hash_table_assert.svh
`ifndef SPATIAL_CELL_HASH_TABLE_ASSERT_SVH
`define SPATIAL_CELL_HASH_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SCHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define SCHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/scht_pkg.sv
package scht_pkg;
    localparam int BUCKETS     = 1024;
    localparam int BUCKET_BITS = $clog2(BUCKETS);
    localparam int M_BITS      = BUCKET_BITS + 1;
    localparam int COORD_BITS  = 10;
    localparam int KEY_BITS    = 3 * COORD_BITS;
    localparam int ENTRY_BITS  = KEY_BITS + 1;
    localparam int WORD_BITS   = 32;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] CFG_COUNT  = 2'd0;
    localparam logic [1:0] CFG_MULT_X = 2'd1;
    localparam logic [1:0] CFG_MULT_Y = 2'd2;
    localparam logic [1:0] CFG_MULT_Z = 2'd3;

    typedef struct packed {
        logic go;
        logic sel_xor;
    } t_hash_cmd;

    typedef struct packed {
        logic                   done;
        logic [BUCKET_BITS-1:0] idx;
    } t_hash_rsp;
endpackage

// File: hdl/scht_ram.sv
module scht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/scht_hash.sv
module scht_hash (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scht_pkg::t_hash_cmd              i_cmd,
    input  logic [scht_pkg::COORD_BITS-1:0]  i_x,
    input  logic [scht_pkg::COORD_BITS-1:0]  i_y,
    input  logic [scht_pkg::COORD_BITS-1:0]  i_z,
    input  logic [scht_pkg::WORD_BITS-1:0]   i_mult_x,
    input  logic [scht_pkg::WORD_BITS-1:0]   i_mult_y,
    input  logic [scht_pkg::WORD_BITS-1:0]   i_mult_z,
    input  logic [scht_pkg::M_BITS-1:0]      i_m,
    output scht_pkg::t_hash_rsp              o_rsp
);
    import scht_pkg::*;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;
    localparam logic [1:0] P_FIN  = 2'd3;
    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic [1:0]           r_phase, n_phase;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_sel, n_sel;
    logic [WORD_BITS-1:0] r_sum, n_sum;
    logic [WORD_BITS-1:0] r_xor, n_xor;
    logic [WORD_BITS-1:0] r_dvd, n_dvd;
    logic [M_BITS-1:0]    r_rem, n_rem;
    logic                 r_neg, n_neg;
    logic                 r_done, n_done;
    logic [BUCKET_BITS-1:0] r_idx, n_idx;

    logic [WORD_BITS-1:0]  mul_a, mul_b, prod, h;
    logic [COORD_BITS-1:0] coord;
    logic [M_BITS:0]       rem2, rem_sub;

    // one shared multiplier, one product per cycle
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    begin mul_a = i_mult_x; coord = i_x; end
            2'd1:    begin mul_a = i_mult_y; coord = i_y; end
            default: begin mul_a = i_mult_z; coord = i_z; end
        endcase
        mul_b = {{(WORD_BITS-COORD_BITS){1'b0}}, coord};
        prod  = mul_a * mul_b;
        h     = r_sel ? r_xor : r_sum;
        rem2    = {r_rem, r_dvd[WORD_BITS-1]};
        rem_sub = rem2 - {1'b0, i_m};
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        n_sum   = r_sum;
        n_xor   = r_xor;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_neg   = r_neg;
        n_done  = 1'b0;
        n_idx   = r_idx;
        unique case (r_phase)
            P_IDLE: begin
                if (i_cmd.go) begin
                    n_phase = P_MUL;
                    n_cnt   = '0;
                    n_sel   = i_cmd.sel_xor;
                    n_sum   = '0;
                    n_xor   = '0;
                end
            end
            P_MUL: begin
                n_sum = r_sum + prod;
                n_xor = r_xor ^ prod;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(2)) begin
                    n_phase = P_FIN;
                end
            end
            P_FIN: begin
                // load magnitude of the hash into the divider
                n_neg   = h[WORD_BITS-1];
                n_dvd   = h[WORD_BITS-1] ? (~h + 1'b1) : h;
                n_rem   = '0;
                n_cnt   = '0;
                n_phase = P_DIV;
            end
            default: begin
                // restoring remainder, one bit a cycle
                n_rem = (rem2 >= {1'b0, i_m}) ? rem_sub[M_BITS-1:0] : rem2[M_BITS-1:0];
                n_dvd = {r_dvd[WORD_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(WORD_BITS - 1)) begin
                    n_phase = P_IDLE;
                    n_done  = 1'b1;
                    n_idx   = (r_neg && n_rem != '0) ? BUCKET_BITS'(i_m - n_rem)
                                                     : BUCKET_BITS'(n_rem);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_cnt <= n_cnt;
        r_sel <= n_sel;
        r_sum <= n_sum;
        r_xor <= n_xor;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_neg <= n_neg;
        r_idx <= n_idx;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.idx  = r_idx;
endmodule

// File: hdl/spatial_cell_hash_table.sv
// insert/lookup: hash the key, then read and check the bucket, then give the result
//   a collision in the first bucket starts a rehash with xor, then linear probing
// clear: one bucket cleared per cycle; unused request code: result with status not found
// one item at a time; busy stays high until the result strobe of an insert, lookup or clear
// reset (synchronous, active low) starts a clearing pass of all buckets with busy high
// the result strobe o_done lasts one cycle and cannot be stalled
`include "spatial_cell_hash_table_assert.svh"

module spatial_cell_hash_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_req_type,
    input  logic [scht_pkg::COORD_BITS-1:0]   i_cell_x,
    input  logic [scht_pkg::COORD_BITS-1:0]   i_cell_y,
    input  logic [scht_pkg::COORD_BITS-1:0]   i_cell_z,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [scht_pkg::WORD_BITS-1:0]    i_cfg_data,
    output logic                              o_done,
    output logic [scht_pkg::BUCKET_BITS-1:0]  o_bucket_index,
    output logic [1:0]                        o_status
);
    import scht_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_HASH = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;

    // configuration registers
    logic [M_BITS-1:0]    r_count;
    logic [WORD_BITS-1:0] r_mult_x, r_mult_y, r_mult_z;

    // sequencer state
    logic [2:0]             r_state, n_state;
    logic [BUCKET_BITS-1:0] r_n, n_n;
    logic [M_BITS-1:0]      r_i, n_i;
    logic                   r_second, n_second;
    logic                   r_insert, n_insert;
    logic                   r_clr_req, n_clr_req;
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic                   r_done, n_done;
    logic [BUCKET_BITS-1:0] r_bidx, n_bidx;
    logic [1:0]             r_status, n_status;

    // hash start pulse tracking: high while a hash is running
    logic                   r_hash_run, n_hash_run;

    logic [M_BITS-1:0]      m;
    logic [BUCKET_BITS-1:0] n_inc;
    t_hash_cmd              hcmd;
    t_hash_rsp              hrsp;
    logic                   ram_we;
    logic [BUCKET_BITS-1:0] ram_waddr;
    logic [ENTRY_BITS-1:0]  ram_wdata, ram_rdata;
    logic                   accept;

    // bucket count clamped to 1..BUCKETS
    always_comb begin
        priority if (r_count == '0) begin
            m = M_BITS'(1);
        end else if (r_count > M_BITS'(BUCKETS)) begin
            m = M_BITS'(BUCKETS);
        end else begin
            m = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= M_BITS'(1024);
            r_mult_x <= WORD_BITS'(73856093);
            r_mult_y <= WORD_BITS'(19349663);
            r_mult_z <= WORD_BITS'(83492791);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COUNT:  r_count  <= i_cfg_data[M_BITS-1:0];
                CFG_MULT_X: r_mult_x <= i_cfg_data;
                CFG_MULT_Y: r_mult_y <= i_cfg_data;
                default:    r_mult_z <= i_cfg_data;
            endcase
        end
    end

    scht_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (hcmd),
        .i_x      (r_key[3*COORD_BITS-1:2*COORD_BITS]),
        .i_y      (r_key[2*COORD_BITS-1:COORD_BITS]),
        .i_z      (r_key[COORD_BITS-1:0]),
        .i_mult_x (r_mult_x),
        .i_mult_y (r_mult_y),
        .i_mult_z (r_mult_z),
        .i_m      (m),
        .o_rsp    (hrsp)
    );

    // entry word: valid bit on top, then x, y, z
    scht_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_n),
        .o_rdata (ram_rdata)
    );

    assign accept = start && (r_state == S_IDLE);
    assign n_inc  = (M_BITS'(r_n) + 1'b1 == m) ? '0 : r_n + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_i       = r_i;
        n_second  = r_second;
        n_insert  = r_insert;
        n_clr_req = r_clr_req;
        n_key     = r_key;
        n_done    = 1'b0;
        n_bidx    = r_bidx;
        n_status  = r_status;
        hcmd      = '0;
        ram_we    = 1'b0;
        ram_waddr = r_n;
        ram_wdata = {1'b1, r_key};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key    = {i_cell_x, i_cell_y, i_cell_z};
                    n_insert = (i_req_type == REQ_INSERT);
                    n_second = 1'b0;
                    n_i      = '0;
                    priority if (i_req_type == REQ_CLEAR) begin
                        n_state   = S_CLR;
                        n_n       = '0;
                        n_clr_req = 1'b1;
                    end else if (i_req_type == REQ_INSERT || i_req_type == REQ_LOOKUP) begin
                        n_state = S_HASH;
                    end else begin
                        // unused request code
                        n_done   = 1'b1;
                        n_bidx   = '0;
                        n_status = ST_NOTFOUND;
                    end
                end
            end
            S_CLR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                n_n       = r_n + 1'b1;
                if (r_n == BUCKET_BITS'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                    if (r_clr_req) begin
                        n_done   = 1'b1;
                        n_bidx   = '0;
                        n_status = ST_OK;
                    end
                    n_clr_req = 1'b0;
                end
            end
            S_HASH: begin
                // command pulse on the first cycle only
                hcmd.go      = !r_hash_run;
                hcmd.sel_xor = r_second;
                if (hrsp.done) begin
                    n_n     = hrsp.idx;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            default: begin
                if (!ram_rdata[ENTRY_BITS-1]) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (r_insert) begin
                        ram_we   = 1'b1;
                        n_bidx   = r_n;
                        n_status = ST_OK;
                    end else begin
                        n_bidx   = '0;
                        n_status = ST_NOTFOUND;
                    end
                end else if (ram_rdata[KEY_BITS-1:0] == r_key) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_bidx   = r_n;
                    n_status = ST_OK;
                end else if (!r_second) begin
                    // first bucket taken by another key: rehash with xor
                    n_second = 1'b1;
                    n_i      = '0;
                    n_state  = S_HASH;
                end else if (r_i + 1'b1 == m) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_bidx   = '0;
                    n_status = ST_FULL;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_n     = n_inc;
                    n_state = S_RD;
                end
            end
        endcase
    end

    always_comb begin
        n_hash_run = r_hash_run;
        if (hcmd.go) begin
            n_hash_run = 1'b1;
        end
        if (hrsp.done) begin
            n_hash_run = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_n        <= '0;
            r_clr_req  <= 1'b0;
            r_done     <= 1'b0;
            r_hash_run <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_n        <= n_n;
            r_clr_req  <= n_clr_req;
            r_done     <= n_done;
            r_hash_run <= n_hash_run;
        end
        r_i      <= n_i;
        r_second <= n_second;
        r_insert <= n_insert;
        r_key    <= n_key;
        r_bidx   <= n_bidx;
        r_status <= n_status;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_bucket_index = r_bidx;
    assign o_status       = r_status;

    `SCHT_ASSERT_IMP(a_idx_zero, i_clk, i_rst_n, o_done && o_status != ST_OK,
        o_bucket_index == '0)
    `SCHT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept && i_req_type != REQ_UNUSED, busy)
    `SCHT_ASSERT_IMP(a_probe_bound, i_clk, i_rst_n, r_state == S_CHK, r_i < m)
    `SCHT_ASSERT_IMP(a_one_hash, i_clk, i_rst_n, hcmd.go, !r_hash_run)
endmodule
